FILE: design/pbmf_pkg.sv
`default_nettype none
package pbmf_pkg;

   localparam int unsigned DEFAULT_MAX_BLOCKS = 65536;
   // bits per bitmap word; fixed so that block numbers split by shift and mask
   localparam int unsigned WORD_BITS = 64;
   localparam int unsigned BIT_W = $clog2(WORD_BITS);
   localparam int unsigned BYTES_PER_WORD = WORD_BITS / 8;

   localparam logic [31:0] NONE_FOUND = 32'hFFFF_FFFF;

   localparam logic OP_MARK = 1'b0;
   localparam logic OP_FIND = 1'b1;

   typedef struct packed {
      logic        operation;
      logic [31:0] block_number;
   } req_type;

   typedef struct packed {
      logic        found;
      logic [31:0] result_block;
      logic        out_of_range;
   } rsp_type;

endpackage
`default_nettype wire

FILE: design/pbmf_ram.sv
`default_nettype none
module pbmf_ram #(
   parameter int unsigned WIDTH = 64,
   parameter int unsigned DEPTH = 1024,
   localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             we,
   input  wire logic [AW-1:0]    waddr,
   input  wire logic [WIDTH-1:0] wdata,
   input  wire logic             re,
   input  wire logic [AW-1:0]    raddr,
   output logic      [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata <= mem[raddr];
      end
   end

endmodule
`default_nettype wire

FILE: design/page_bitmap_mark_and_find_next_unit.sv
`default_nettype none
// Channel   Ports                        Direction  Transfer
// request   start, busy, req_data        in         start & !busy
// response  rsp_valid, rsp_data          out        rsp_valid, one cycle, no stall
//
// Mark: word read, then OR-in and write back.
// Find: scans words up to the first non-zero one or the last word (one RAM
//   read per cycle sets the pace), then a per-byte encode and a pick.
// Out-of-range mark or find: answered the next cycle, busy stays low.
// After reset the bitmap RAM is zeroed one word a cycle, all NUM_WORDS words
//   (1024 at default size), with busy high.
// Responses cannot be stalled; each is presented for exactly one cycle.
module page_bitmap_mark_and_find_next_unit #(
   parameter int unsigned MAX_BLOCKS = pbmf_pkg::DEFAULT_MAX_BLOCKS
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire pbmf_pkg::req_type req_data,
   output logic                   rsp_valid,
   output pbmf_pkg::rsp_type      rsp_data
);

   import pbmf_pkg::*;

   localparam int unsigned NUM_WORDS = (MAX_BLOCKS + WORD_BITS - 1) / WORD_BITS;
   localparam int unsigned ADDR_W = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
   localparam logic [ADDR_W-1:0] LAST_WORD = ADDR_W'(NUM_WORDS - 1);
   localparam logic [31:0] LIMIT = 32'(MAX_BLOCKS);

   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_MARK  = 3'd2;  // read data back, write merged word
   localparam logic [2:0] ST_SCAN  = 3'd3;  // one word per cycle
   localparam logic [2:0] ST_ENC   = 3'd4;  // per-byte lowest set bit
   localparam logic [2:0] ST_PICK  = 3'd5;  // first non-zero byte, respond

   logic [2:0]        state_ff, state_in;
   logic [ADDR_W-1:0] idx_ff, idx_in;
   logic [BIT_W-1:0]  bit_ff, bit_in;
   logic [WORD_BITS-1:0] mask_ff, mask_in;
   logic [WORD_BITS-1:0] word_ff, word_in;
   logic [BYTES_PER_WORD-1:0]      byte_nz_ff, byte_nz_in;
   logic [BYTES_PER_WORD-1:0][2:0] byte_low_ff, byte_low_in;
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;

   logic                 ram_we, ram_re;
   logic [ADDR_W-1:0]    ram_waddr, ram_raddr;
   logic [WORD_BITS-1:0] ram_wdata, ram_rdata;

   logic                 in_range;
   logic [ADDR_W-1:0]    req_idx;
   logic [WORD_BITS-1:0] scan_word;
   logic [$clog2(BYTES_PER_WORD)-1:0] sel;

   pbmf_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (NUM_WORDS)
   ) u_bits (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign in_range  = (req_data.block_number < LIMIT);
   assign req_idx   = req_data.block_number[ADDR_W+BIT_W-1:BIT_W];
   // first word of a find drops the bits below the start position
   assign scan_word = ram_rdata & mask_ff;

   // per-byte encoders, registered before the final pick
   always_comb begin
      byte_nz_in  = '0;
      byte_low_in = '0;
      for (int g = 0; g < BYTES_PER_WORD; g++) begin
         byte_nz_in[g] = |word_ff[8*g +: 8];
         for (int b = 7; b >= 0; b--) begin
            if (word_ff[8*g + b]) begin
               byte_low_in[g] = 3'(b);
            end
         end
      end
   end

   always_comb begin
      sel = '0;
      for (int g = BYTES_PER_WORD - 1; g >= 0; g--) begin
         if (byte_nz_ff[g]) begin
            sel = ($clog2(BYTES_PER_WORD))'(g);
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      bit_in       = bit_ff;
      mask_in      = mask_ff;
      word_in      = word_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      ram_we       = 1'b0;
      ram_waddr    = idx_ff;
      ram_wdata    = '0;
      ram_re       = 1'b0;
      ram_raddr    = idx_ff;

      unique case (state_ff)
         ST_CLEAR: begin
            ram_we = 1'b1;
            if (idx_ff == LAST_WORD) begin
               idx_in   = '0;
               state_in = ST_IDLE;
            end else begin
               idx_in = idx_ff + ADDR_W'(1);
            end
         end
         ST_IDLE: begin
            if (start) begin
               idx_in  = req_idx;
               bit_in  = req_data.block_number[BIT_W-1:0];
               mask_in = {WORD_BITS{1'b1}} << req_data.block_number[BIT_W-1:0];
               if (in_range) begin
                  ram_re    = 1'b1;
                  ram_raddr = req_idx;
                  state_in  = (req_data.operation == OP_MARK) ? ST_MARK : ST_SCAN;
               end else begin
                  // refused without touching the bitmap
                  rsp_valid_in        = 1'b1;
                  rsp_in.found        = 1'b0;
                  rsp_in.result_block = NONE_FOUND;
                  rsp_in.out_of_range = (req_data.operation == OP_MARK);
               end
            end
         end
         ST_MARK: begin
            ram_we              = 1'b1;
            ram_wdata           = ram_rdata | (WORD_BITS'(1) << bit_ff);
            rsp_valid_in        = 1'b1;
            rsp_in.found        = 1'b0;
            rsp_in.result_block = NONE_FOUND;
            rsp_in.out_of_range = 1'b0;
            state_in            = ST_IDLE;
         end
         ST_SCAN: begin
            // prefetch the next word while this one is tested
            ram_re    = 1'b1;
            ram_raddr = idx_ff + ADDR_W'(1);
            mask_in   = '1;
            if (scan_word != '0) begin
               word_in  = scan_word;
               state_in = ST_ENC;
            end else if (idx_ff == LAST_WORD) begin
               rsp_valid_in        = 1'b1;
               rsp_in.found        = 1'b0;
               rsp_in.result_block = NONE_FOUND;
               rsp_in.out_of_range = 1'b0;
               state_in            = ST_IDLE;
            end else begin
               idx_in = idx_ff + ADDR_W'(1);
            end
         end
         ST_ENC: begin
            state_in = ST_PICK;
         end
         ST_PICK: begin
            // bits at or past capacity are never set, so the hit is in range
            rsp_valid_in        = 1'b1;
            rsp_in.found        = 1'b1;
            rsp_in.result_block = 32'({idx_ff, sel, byte_low_ff[sel]});
            rsp_in.out_of_range = 1'b0;
            state_in            = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      bit_ff      <= bit_in;
      mask_ff     <= mask_in;
      word_ff     <= word_in;
      byte_nz_ff  <= byte_nz_in;
      byte_low_ff <= byte_low_in;
      rsp_ff      <= rsp_in;
   end

endmodule
`default_nettype wire

FILE: test/pbmf_bitmap_checker.sv
`timescale 1ns / 100ps
`default_nettype none
module pbmf_bitmap_checker #(
   parameter int unsigned MAX_BLOCKS = pbmf_pkg::DEFAULT_MAX_BLOCKS
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic              busy,
   input  wire pbmf_pkg::req_type req_data,
   input  wire logic              rsp_valid,
   input  wire pbmf_pkg::rsp_type rsp_data,
   output int unsigned            fault_count,
   output int unsigned            pending_count
);
   import pbmf_pkg::*;

   localparam int unsigned NUM_WORDS = (MAX_BLOCKS + WORD_BITS - 1) / WORD_BITS;

   // shadow copy of the change bitmap
   logic [WORD_BITS-1:0] marked_words [NUM_WORDS];
   // answers owed by the unit, oldest first
   rsp_type answers_q [$];

   function automatic rsp_type mark_or_find(req_type item);
      rsp_type              answer;
      int unsigned          idx;
      int unsigned          bitpos;
      int unsigned          low;
      logic [WORD_BITS-1:0] word;
      logic                 scanning;
      answer = '{found: 1'b0, result_block: NONE_FOUND, out_of_range: 1'b0};
      low = 0;
      if (item.block_number >= MAX_BLOCKS) begin
         if (item.operation == OP_MARK) begin
            answer.out_of_range = 1'b1;
         end
      end else begin
         idx    = item.block_number / WORD_BITS;
         bitpos = item.block_number % WORD_BITS;
         if (item.operation == OP_MARK) begin
            marked_words[idx][bitpos] = 1'b1;
         end else begin
            // drop bits below the start, then walk the words upward
            word     = (marked_words[idx] >> bitpos) << bitpos;
            scanning = 1'b1;
            while (scanning) begin
               if (word != '0) begin
                  for (int b = WORD_BITS - 1; b >= 0; b--) begin
                     if (word[b]) begin
                        low = b;
                     end
                  end
                  if (idx * WORD_BITS + low < MAX_BLOCKS) begin
                     answer.found        = 1'b1;
                     answer.result_block = idx * WORD_BITS + low;
                  end
                  scanning = 1'b0;
               end else if (idx + 1 >= NUM_WORDS) begin
                  scanning = 1'b0;
               end else begin
                  idx++;
                  word = marked_words[idx];
               end
            end
         end
      end
      return answer;
   endfunction

   always @(posedge clock) begin
      rsp_type     want;
      int unsigned faults;
      faults = 0;
      if (reset) begin
         answers_q.delete();
         for (int w = 0; w < NUM_WORDS; w++) begin
            marked_words[w] = '0;
         end
         pending_count <= 0;
      end else begin
         // a result seen at this edge always belongs to an earlier transaction
         if (rsp_valid) begin
            if (answers_q.size() == 0) begin
               $error("result with no transaction outstanding: %p", rsp_data);
               faults++;
            end else begin
               want = answers_q.pop_front();
               if (rsp_data.found !== want.found) begin
                  $error("found: expected %0d, actual %0d", want.found, rsp_data.found);
                  faults++;
               end
               if (rsp_data.result_block !== want.result_block) begin
                  $error("result_block: expected %0h, actual %0h",
                         want.result_block, rsp_data.result_block);
                  faults++;
               end
               if (rsp_data.out_of_range !== want.out_of_range) begin
                  $error("out_of_range: expected %0d, actual %0d",
                         want.out_of_range, rsp_data.out_of_range);
                  faults++;
               end
            end
         end
         if (start && !busy) begin
            answers_q.push_back(mark_or_find(req_data));
         end
         pending_count <= answers_q.size();
      end
      fault_count <= fault_count + faults;
   end

endmodule
`default_nettype wire

FILE: test/tb_page_bitmap_mark_and_find_next_unit.sv
`timescale 1ns / 100ps
`default_nettype none
// Stimulus and verdict for the changed-block bitmap unit. The checker beside
// the unit watches both channels, keeps its own bitmap and compares every
// answer; this module only feeds transactions and decides pass or fail.
module tb_page_bitmap_mark_and_find_next_unit;
   import pbmf_pkg::*;

   localparam int unsigned MAX_BLOCKS   = DEFAULT_MAX_BLOCKS;
   localparam int unsigned NUM_WORDS    = (MAX_BLOCKS + WORD_BITS - 1) / WORD_BITS;
   localparam int unsigned RANDOM_ITEMS = 850;
   // slowest legal run: every find a full scan plus the longest sender gap,
   // plus the clearing pass; taken several times over
   localparam int unsigned CYCLE_LIMIT  = 5_000_000;
   // a full-length find is the longest the unit can keep an answer back
   localparam int unsigned TAIL_CYCLES  = NUM_WORDS + 16;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   req_type     req_data = '0;
   logic        rsp_valid;
   rsp_type     rsp_data;
   int unsigned fault_count;
   int unsigned pending_count;
   int unsigned cycle_count = 0;
   // transactions left before the sender next pauses
   int unsigned burst_left = 0;

   always #5 clock = ~clock;

   page_bitmap_mark_and_find_next_unit #(
      .MAX_BLOCKS(MAX_BLOCKS)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_data (rsp_data)
   );

   pbmf_bitmap_checker #(
      .MAX_BLOCKS(MAX_BLOCKS)
   ) checker_i (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_data     (rsp_data),
      .fault_count  (fault_count),
      .pending_count(pending_count)
   );

   // Hold one transaction on the request port until the unit takes it
   // (start high, busy low at an edge). Start stays up across back-to-back
   // transactions; at the end of a burst it drops for a random gap and the
   // payload is filled with junk so that nothing leans on stale data.
   task automatic send_item(input logic op, input logic [31:0] blk);
      int unsigned gap;
      start    <= 1'b1;
      req_data <= '{operation: op, block_number: blk};
      do @(posedge clock); while (busy);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         gap = $urandom_range(1, 6);
         // now and then a long stretch with no pause at all
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(0, 10);
         start    <= 1'b0;
         req_data <= '{operation: 1'($urandom_range(0, 1)), block_number: $urandom};
         repeat (gap) @(posedge clock);
      end
   endtask

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   initial begin
      logic [31:0] blk;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      // the unit clears its RAM next with busy high; send_item simply waits

      // --- directed ---
      // searches on an empty map: a full scan, the last block, past capacity
      send_item(OP_FIND, 32'd0);
      send_item(OP_FIND, MAX_BLOCKS - 1);
      send_item(OP_FIND, MAX_BLOCKS);
      send_item(OP_FIND, 32'hFFFF_FFFF);
      // first and last blocks, then marks past capacity that must be refused
      send_item(OP_MARK, 32'd0);
      send_item(OP_MARK, MAX_BLOCKS - 1);
      send_item(OP_MARK, MAX_BLOCKS);
      send_item(OP_MARK, 32'hFFFF_FFFF);
      // mark of a block already set
      send_item(OP_MARK, 32'd0);
      send_item(OP_FIND, 32'd0);
      send_item(OP_FIND, 32'd1);
      send_item(OP_FIND, MAX_BLOCKS - 1);
      // either side of a word boundary
      send_item(OP_MARK, WORD_BITS - 1);
      send_item(OP_MARK, WORD_BITS);
      send_item(OP_FIND, 32'd1);
      send_item(OP_FIND, WORD_BITS);
      send_item(OP_FIND, WORD_BITS + 1);
      send_item(OP_MARK, 32'h8000_0000);
      send_item(OP_FIND, 32'hAAAA_AAAA);
      send_item(OP_MARK, 32'h5555_5555);
      // last word of the map
      send_item(OP_MARK, MAX_BLOCKS - WORD_BITS);
      send_item(OP_FIND, MAX_BLOCKS - 2 * WORD_BITS + 1);

      // --- random ---
      // mostly in-range blocks, weighted toward word edges, the low end and
      // the top of the map, with a share of full 32-bit noise past capacity
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         case ($urandom_range(0, 9)) inside
            [0:3]:   blk = $urandom_range(0, MAX_BLOCKS - 1);
            4:       blk = $urandom_range(0, NUM_WORDS - 1) * WORD_BITS
                           + ($urandom_range(0, 1) ? WORD_BITS - 1 : 0);
            5:       blk = $urandom_range(0, 255);
            6:       blk = MAX_BLOCKS - 1 - $urandom_range(0, 200);
            7:       blk = MAX_BLOCKS + $urandom_range(0, 3);
            default: blk = $urandom;
         endcase
         send_item($urandom_range(0, 1) ? OP_FIND : OP_MARK, blk);
      end
      start <= 1'b0;

      // let the checker see the last transaction before asking what is owed
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      if (fault_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
`default_nettype wire
